FILE: src/zcfam_pkg.sv
// ----------------------------------------------------------------------------
// zcfam_pkg
// Shared types and constants for the zero-cross frequency / amplitude meter.
// ----------------------------------------------------------------------------
package zcfam_pkg;

    localparam int MAX_WINDOW_DEF = 1024;

    localparam int SAMPLE_W   = 10;
    localparam int TIME_W     = 32;
    localparam int THR_W      = 10;
    localparam int WLEN_W     = 11;
    localparam int CFG_DATA_W = 11;
    localparam int PP_W       = 10;
    localparam int FREQ_W     = 30;
    localparam int PCNT_W     = 2;

    // stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(512);
    localparam logic [WLEN_W-1:0]   WLEN_RESET   = WLEN_W'(1024);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = '1;
    localparam logic [TIME_W-1:0]   SCALE_MHZ    = 32'd1000000000;
    localparam logic [FREQ_W-1:0]   FREQ_SAT     = 30'd1000000000;
    localparam logic [PCNT_W-1:0]   PERIODS_STOP = PCNT_W'(2);

    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_WINDOW    = 1'b1;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_RISE = 2'd1,
        DIR_FALL = 2'd2
    } cross_dir_t;

    typedef enum logic [1:0] {
        B_IDLE  = 2'd0,
        B_CALC  = 2'd1,
        B_WRITE = 2'd2
    } back_state_t;

    // one finished window, front to back
    typedef struct packed {
        logic [PP_W-1:0]   pp;
        logic              freq_on;
        logic [TIME_W-1:0] period;
        logic [PCNT_W-1:0] pcount;
    } win_rec_t;

endpackage

FILE: src/zcfam_front.sv
// ----------------------------------------------------------------------------
// zcfam_front
// Per-sample tracking: min/max, threshold crossings, period timing, window end.
// ----------------------------------------------------------------------------
module zcfam_front #(
    parameter int MAX_WINDOW = zcfam_pkg::MAX_WINDOW_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_addr,
    input  logic [zcfam_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                             accept,
    input  logic [zcfam_pkg::SAMPLE_W-1:0]   sample,
    input  logic [zcfam_pkg::TIME_W-1:0]     time_us,
    input  logic                             want_frequency,
    output logic                             push,
    output zcfam_pkg::win_rec_t              rec
);

    localparam int IDX_W = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (CNT_W > zcfam_pkg::WLEN_W) ? CNT_W : zcfam_pkg::WLEN_W;

    logic [zcfam_pkg::THR_W-1:0]    thr_reg;
    logic [zcfam_pkg::WLEN_W-1:0]   wlen_reg;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [zcfam_pkg::SAMPLE_W-1:0] prev_reg;
    logic [zcfam_pkg::SAMPLE_W-1:0] max_reg, max_next;
    logic [zcfam_pkg::SAMPLE_W-1:0] min_reg, min_next;
    zcfam_pkg::cross_dir_t          dir_reg, dir_next;
    logic [zcfam_pkg::TIME_W-1:0]   etime_reg, etime_next;
    logic                           seen_reg, seen_next;
    logic [zcfam_pkg::PCNT_W-1:0]   pc_reg, pc_next;
    logic [zcfam_pkg::TIME_W-1:0]   per_reg, per_next;
    logic                           fmode_reg, fmode_next;

    logic [CNT_W-1:0]               len_eff;
    logic [CNT_W-1:0]               idx_p1;
    logic                           first;
    logic [zcfam_pkg::SAMPLE_W-1:0] b_max, b_min, t_max, t_min, r_max, r_min;
    zcfam_pkg::cross_dir_t          b_dir;
    logic [zcfam_pkg::TIME_W-1:0]   b_etime, b_per;
    logic                           b_seen;
    logic [zcfam_pkg::PCNT_W-1:0]   b_pc;
    logic                           rise, fall, crossed, early, win_end;

    // clamp window length to [2, MAX_WINDOW]
    always_comb
    begin
        if (wlen_reg < zcfam_pkg::WLEN_W'(2))
            len_eff = CNT_W'(2);
        else if (CMP_W'(wlen_reg) > CMP_W'(MAX_WINDOW))
            len_eff = CNT_W'(MAX_WINDOW);
        else
            len_eff = CNT_W'(wlen_reg);
    end

    assign idx_p1 = CNT_W'(idx_reg) + CNT_W'(1);
    assign first  = (idx_reg == '0);

    always_comb
    begin
        fmode_next = first ? want_frequency : fmode_reg;
        b_max      = first ? '0 : max_reg;
        b_min      = first ? zcfam_pkg::SAMPLE_MAX : min_reg;
        b_dir      = first ? zcfam_pkg::DIR_NONE : dir_reg;
        b_etime    = first ? '0 : etime_reg;
        b_seen     = first ? 1'b0 : seen_reg;
        b_pc       = first ? '0 : pc_reg;
        b_per      = first ? '0 : per_reg;

        rise = (prev_reg <= thr_reg) && (sample > thr_reg);
        fall = (prev_reg >= thr_reg) && (sample < thr_reg);

        dir_next = b_dir;
        case (b_dir)
            zcfam_pkg::DIR_NONE:
            begin
                crossed = rise || fall;
                // edge kind is fixed only by a tracked crossing
                if (fmode_next && !first)
                begin
                    if (rise)
                        dir_next = zcfam_pkg::DIR_RISE;
                    else if (fall)
                        dir_next = zcfam_pkg::DIR_FALL;
                end
            end
            zcfam_pkg::DIR_RISE: crossed = rise;
            zcfam_pkg::DIR_FALL: crossed = fall;
            default:             crossed = 1'b0;
        endcase

        etime_next = b_etime;
        seen_next  = b_seen;
        pc_next    = b_pc;
        per_next   = b_per;
        early      = 1'b0;
        if (fmode_next && !first && crossed)
        begin
            if (b_seen)
            begin
                per_next = time_us - b_etime;
                pc_next  = b_pc + zcfam_pkg::PCNT_W'(1);
                early    = (pc_next >= zcfam_pkg::PERIODS_STOP);
            end
            if (!early)
            begin
                etime_next = time_us;
                seen_next  = 1'b1;
            end
        end

        t_max = (sample > b_max) ? sample : b_max;
        t_min = (sample < b_min) ? sample : b_min;
        // second period closes the window before this sample counts
        r_max = early ? b_max : t_max;
        r_min = early ? b_min : t_min;
        max_next = r_max;
        min_next = r_min;

        win_end  = early || (idx_p1 >= len_eff);
        idx_next = win_end ? '0 : IDX_W'(idx_p1);

        rec.pp      = (r_max >= r_min) ? (r_max - r_min) : '0;
        rec.freq_on = fmode_next && (pc_next != '0);
        rec.period  = per_next;
        rec.pcount  = pc_next;
        push        = accept && win_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= zcfam_pkg::THR_RESET;
            wlen_reg  <= zcfam_pkg::WLEN_RESET;
            idx_reg   <= '0;
            prev_reg  <= '0;
            max_reg   <= '0;
            min_reg   <= zcfam_pkg::SAMPLE_MAX;
            dir_reg   <= zcfam_pkg::DIR_NONE;
            etime_reg <= '0;
            seen_reg  <= 1'b0;
            pc_reg    <= '0;
            per_reg   <= '0;
            fmode_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    zcfam_pkg::REG_THRESHOLD: thr_reg  <= zcfam_pkg::THR_W'(cfg_wdata);
                    zcfam_pkg::REG_WINDOW:    wlen_reg <= cfg_wdata;
                    default:                  ;
                endcase
            end
            if (accept)
            begin
                idx_reg   <= idx_next;
                prev_reg  <= sample;
                max_reg   <= max_next;
                min_reg   <= min_next;
                dir_reg   <= dir_next;
                etime_reg <= etime_next;
                seen_reg  <= seen_next;
                pc_reg    <= pc_next;
                per_reg   <= per_next;
                fmode_reg <= fmode_next;
            end
        end
    end

endmodule

FILE: src/zcfam_queue.sv
// ----------------------------------------------------------------------------
// zcfam_queue
// Short FIFO of finished-window records between front and back.
// ----------------------------------------------------------------------------
module zcfam_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  zcfam_pkg::win_rec_t wr_rec,
    input  logic                pop,
    output zcfam_pkg::win_rec_t rd_rec,
    output logic                not_empty,
    output logic                full
);

    localparam int PTR_W = $clog2(zcfam_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(zcfam_pkg::QUEUE_DEPTH + 1);

    zcfam_pkg::win_rec_t mem_reg [zcfam_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                do_push, do_pop;

    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == CNT_W'(zcfam_pkg::QUEUE_DEPTH));
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rd_rec    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(zcfam_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(zcfam_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

endmodule

FILE: src/zcfam_back.sv
// ----------------------------------------------------------------------------
// zcfam_back
// Window result: radix-2 restoring divide for the frequency, output register.
// ----------------------------------------------------------------------------
module zcfam_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  zcfam_pkg::win_rec_t           rec,
    input  logic                          rec_valid,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [zcfam_pkg::PP_W-1:0]    out_pp,
    output logic [zcfam_pkg::FREQ_W-1:0]  out_freq,
    output logic [zcfam_pkg::PCNT_W-1:0]  out_pcount
);

    localparam int DW  = zcfam_pkg::TIME_W;
    localparam int CTW = $clog2(DW);

    zcfam_pkg::back_state_t        state_reg, state_next;
    logic [DW-1:0]                 rem_reg, rem_next;
    logic [DW-1:0]                 quo_reg, quo_next;
    logic [DW-1:0]                 div_reg, div_next;
    logic [CTW-1:0]                cnt_reg, cnt_next;
    logic [zcfam_pkg::PP_W-1:0]    pp_reg, pp_next;
    logic [zcfam_pkg::PCNT_W-1:0]  pc_reg, pc_next;
    logic                          ovld_reg, ovld_next;
    logic [zcfam_pkg::PP_W-1:0]    opp_reg, opp_next;
    logic [zcfam_pkg::FREQ_W-1:0]  ofreq_reg, ofreq_next;
    logic [zcfam_pkg::PCNT_W-1:0]  opc_reg, opc_next;
    logic [DW:0]                   trial;
    logic                          fits;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        pp_next    = pp_reg;
        pc_next    = pc_reg;
        ovld_next  = ovld_reg && !out_ready;
        opp_next   = opp_reg;
        ofreq_next = ofreq_reg;
        opc_next   = opc_reg;
        pop        = 1'b0;

        case (state_reg)
            zcfam_pkg::B_IDLE:
            begin
                if (rec_valid)
                begin
                    pop     = 1'b1;
                    pp_next = rec.pp;
                    pc_next = rec.pcount;
                    if (!rec.freq_on)
                    begin
                        quo_next   = '0;
                        state_next = zcfam_pkg::B_WRITE;
                    end
                    else if (rec.period == '0)
                    begin
                        quo_next   = DW'(zcfam_pkg::FREQ_SAT);
                        state_next = zcfam_pkg::B_WRITE;
                    end
                    else
                    begin
                        // round half up: (1e9 + p/2) / p
                        quo_next   = zcfam_pkg::SCALE_MHZ + (rec.period >> 1);
                        rem_next   = '0;
                        div_next   = rec.period;
                        cnt_next   = '0;
                        state_next = zcfam_pkg::B_CALC;
                    end
                end
            end
            zcfam_pkg::B_CALC:
            begin
                rem_next = fits ? DW'(trial - {1'b0, div_reg}) : trial[DW-1:0];
                quo_next = {quo_reg[DW-2:0], fits};
                cnt_next = cnt_reg + CTW'(1);
                if (cnt_reg == CTW'(DW - 1))
                    state_next = zcfam_pkg::B_WRITE;
            end
            zcfam_pkg::B_WRITE:
            begin
                if (!ovld_reg || out_ready)
                begin
                    ovld_next  = 1'b1;
                    opp_next   = pp_reg;
                    ofreq_next = quo_reg[zcfam_pkg::FREQ_W-1:0];
                    opc_next   = pc_reg;
                    state_next = zcfam_pkg::B_IDLE;
                end
            end
            default:
                state_next = zcfam_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= zcfam_pkg::B_IDLE;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        div_reg   <= div_next;
        cnt_reg   <= cnt_next;
        pp_reg    <= pp_next;
        pc_reg    <= pc_next;
        opp_reg   <= opp_next;
        ofreq_reg <= ofreq_next;
        opc_reg   <= opc_next;
    end

    assign out_valid  = ovld_reg;
    assign out_pp     = opp_reg;
    assign out_freq   = ofreq_reg;
    assign out_pcount = opc_reg;

endmodule

FILE: src/zero_cross_frequency_amplitude_meter.sv
// ----------------------------------------------------------------------------
// zero_cross_frequency_amplitude_meter
// Windowed peak-to-peak and zero-crossing frequency meter for raw ADC samples.
// ----------------------------------------------------------------------------
// Samples stream in with a microsecond timestamp and are grouped into windows
// of window_length samples (clamped to 2..MAX_WINDOW). The front end takes one
// sample per clock while the result queue has room, tracks min/max, finds
// threshold crossings of one edge kind (fixed by the first crossing of the
// window) and times the periods between them; a window closes early once a
// second period completes. Each window yields one result request. The back end
// computes frequency_mhz = round(1e9 / period) with a one-bit-per-cycle
// restoring divider, which is skipped when no frequency is measured. A
// two-deep queue separates the two, so sampling stalls only if windows finish
// faster than the back end drains them (e.g. very short windows with frequency
// on, or a stalled result stream); otherwise the rate is one sample per cycle.
// Configuration writes are taken at any time but belong in idle periods.
// ----------------------------------------------------------------------------
module zero_cross_frequency_amplitude_meter #(
    parameter int MAX_WINDOW = zcfam_pkg::MAX_WINDOW_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration: index 0 zero_threshold, index 1 window_length
    input  logic                              cfg_wr_en,
    input  logic                              cfg_addr,
    input  logic [zcfam_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // sample stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [9:0] sample, [41:10] time_us, [42] want_frequency, rest zero
    input  logic [zcfam_pkg::IN_TDATA_W-1:0]  s_tdata,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [9:0] peak_to_peak, [39:10] frequency_mhz, [41:40] periods_seen, rest zero
    output logic [zcfam_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int T_LO = zcfam_pkg::SAMPLE_W;
    localparam int W_BIT = zcfam_pkg::SAMPLE_W + zcfam_pkg::TIME_W;
    localparam int F_LO = zcfam_pkg::PP_W;
    localparam int P_LO = zcfam_pkg::PP_W + zcfam_pkg::FREQ_W;
    localparam int O_USED = P_LO + zcfam_pkg::PCNT_W;

    logic                             accept;
    logic                             push;
    logic                             q_full;
    logic                             q_not_empty;
    logic                             pop;
    zcfam_pkg::win_rec_t              wr_rec, rd_rec;
    logic [zcfam_pkg::PP_W-1:0]       out_pp;
    logic [zcfam_pkg::FREQ_W-1:0]     out_freq;
    logic [zcfam_pkg::PCNT_W-1:0]     out_pcount;

    // room must exist for a window result before any sample is taken
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    zcfam_front #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .accept         (accept),
        .sample         (s_tdata[T_LO-1:0]),
        .time_us        (s_tdata[W_BIT-1:T_LO]),
        .want_frequency (s_tdata[W_BIT]),
        .push           (push),
        .rec            (wr_rec)
    );

    zcfam_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_rec    (wr_rec),
        .pop       (pop),
        .rd_rec    (rd_rec),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    zcfam_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec        (rd_rec),
        .rec_valid  (q_not_empty),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pp     (out_pp),
        .out_freq   (out_freq),
        .out_pcount (out_pcount)
    );

    assign m_tdata = {{(zcfam_pkg::OUT_TDATA_W - O_USED){1'b0}}, out_pcount, out_freq, out_pp};

endmodule

FILE: src/zcfam_checker.sv
// ----------------------------------------------------------------------------
// zcfam_checker
// Port-level checks on the meter's result stream.
// ----------------------------------------------------------------------------
module zcfam_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [zcfam_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // stalled result holds its data
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a window never reports more than two periods
    a_pcount: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[41:40] != 2'b11)
        else $error("periods_seen out of range");

    // frequency saturates at 1e9 mHz
    a_freq_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[39:10] <= 30'd1000000000)
        else $error("frequency out of range");

    // no period measured means no frequency
    a_freq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[41:40] == 2'b00 |-> m_tdata[39:10] == 30'd0)
        else $error("frequency without a period");

endmodule

bind zero_cross_frequency_amplitude_meter zcfam_checker u_zcfam_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/sv/zero_cross_frequency_amplitude_meter_test.sv
// ----------------------------------------------------------------------------
// zero_cross_frequency_amplitude_meter_test
// Self-checking bench for the windowed peak-to-peak / zero-cross frequency meter.
// ----------------------------------------------------------------------------
// A cycle-free software copy of the meter runs beside the block. Each accepted
// sample request is fed to it, and every finished window pushes a predicted
// reading. A monitor pops the oldest prediction for each reading request the
// block hands out and compares the three fields. Stimulus is a directed set of
// short windows (extremes, timestamp wrap, zero period, mid-window register
// changes), then phases of square-ish waves around the threshold with random
// jitter, noise bursts and timing, and one window of the largest length.
// ----------------------------------------------------------------------------
module zero_cross_frequency_amplitude_meter_test;

    timeunit 1ns;
    timeprecision 1ps;

    import zcfam_pkg::*;

    // time for the back end to finish a window, with a wide margin
    localparam int QUIET_CYCLES  = 64;
    // cycles with no request, result or register write before giving up
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_SAMPLES = 30;

    // one predicted or observed window result
    typedef struct packed {
        logic [PP_W-1:0]   pp;
        logic [FREQ_W-1:0] freq;
        logic [PCNT_W-1:0] periods;
    } meter_reading_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic                   cfg_addr = REG_THRESHOLD;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // ---- predictor state: register copies and per-window tracking ----
    logic [THR_W-1:0]    cur_thr = THR_RESET;
    logic [WLEN_W-1:0]   cur_len = WLEN_RESET;
    logic [WLEN_W-1:0]   win_pos = '0;
    logic [SAMPLE_W-1:0] last_smp = '0;
    logic [SAMPLE_W-1:0] peak_hi = '0;
    logic [SAMPLE_W-1:0] peak_lo = SAMPLE_MAX;
    cross_dir_t          edge_kind = DIR_NONE;
    logic [TIME_W-1:0]   mark_time = '0;
    logic                marked = 1'b0;
    logic [PCNT_W-1:0]   period_cnt = '0;
    logic [TIME_W-1:0]   period_us = '0;
    logic                freq_on = 1'b0;

    meter_reading_t pending_readings[$];

    // ---- traffic shaping ----
    bit          gaps_on = 1'b0;
    bit          stalls_on = 1'b0;
    int          burst_left = 0;
    logic [15:0] stall_pattern = 16'b1100_1110_1001_1101;

    int error_count = 0;
    int samples_sent = 0;
    int readings_checked = 0;
    int reg_writes = 0;
    int quiet_cycles = 0;

    zero_cross_frequency_amplitude_meter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // rounded 1e9 / period, ties up; zero period saturates
    function automatic logic [FREQ_W-1:0] to_millihertz(logic [TIME_W-1:0] per);
        longint unsigned p;
        longint unsigned q;
        p = 64'(per);
        if (p == 0)
            return FREQ_SAT;
        q = (longint'(SCALE_MHZ) + p / 2) / p;
        return FREQ_W'(q);
    endfunction

    function automatic void close_window();
        meter_reading_t r;
        r.pp      = (peak_hi >= peak_lo) ? peak_hi - peak_lo : '0;
        r.freq    = (freq_on && period_cnt != 0) ? to_millihertz(period_us) : '0;
        r.periods = period_cnt;
        pending_readings.push_back(r);
        win_pos = '0;
    endfunction

    // advance the meter copy by one accepted sample
    function automatic void predict_sample(logic [SAMPLE_W-1:0] smp,
                                           logic [TIME_W-1:0] t, logic want);
        int   eff_len;
        logic rise;
        logic fall;
        logic hit;
        eff_len = int'(cur_len);
        if (eff_len < 2)
            eff_len = 2;
        if (eff_len > MAX_WINDOW_DEF)
            eff_len = MAX_WINDOW_DEF;

        // window start: drop all tracking, latch the frequency request
        if (win_pos == 0)
        begin
            peak_hi    = '0;
            peak_lo    = SAMPLE_MAX;
            edge_kind  = DIR_NONE;
            mark_time  = '0;
            marked     = 1'b0;
            period_cnt = '0;
            period_us  = '0;
            freq_on    = want;
        end

        // no crossing possible on the window's first sample
        if (freq_on && win_pos != 0)
        begin
            rise = (last_smp <= cur_thr) && (smp > cur_thr);
            fall = (last_smp >= cur_thr) && (smp < cur_thr);
            hit  = 1'b0;
            case (edge_kind)
                DIR_NONE:
                begin
                    // first crossing fixes the edge kind, rising checked first
                    if (rise)
                    begin
                        edge_kind = DIR_RISE;
                        hit = 1'b1;
                    end
                    else if (fall)
                    begin
                        edge_kind = DIR_FALL;
                        hit = 1'b1;
                    end
                end
                DIR_RISE: hit = rise;
                DIR_FALL: hit = fall;
                default:  hit = 1'b0;
            endcase
            if (hit)
            begin
                if (marked)
                begin
                    period_us  = t - mark_time;
                    period_cnt = period_cnt + 1'b1;
                    // second period: stop before this sample enters min/max
                    if (period_cnt >= PERIODS_STOP)
                    begin
                        close_window();
                        last_smp = smp;
                        return;
                    end
                end
                mark_time = t;
                marked    = 1'b1;
            end
        end

        if (smp > peak_hi)
            peak_hi = smp;
        if (smp < peak_lo)
            peak_lo = smp;
        last_smp = smp;

        if (int'(win_pos) + 1 >= eff_len)
            close_window();
        else
            win_pos = win_pos + 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // receiver: rotating stall pattern, or always ready
    always @(negedge clk)
    begin
        m_tready      <= stalls_on ? stall_pattern[0] : 1'b1;
        stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
    end

    // Send one sample request. Called at a falling edge, returns at one with
    // tvalid still high so back-to-back calls keep the bus busy.
    task automatic send_sample(logic [SAMPLE_W-1:0] smp, logic [TIME_W-1:0] t,
                               logic want);
        int gap;
        if (gaps_on && burst_left <= 0)
        begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        s_tdata  <= {5'b0, want, t, smp};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predict_sample(smp, t, want);
        samples_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    // drop the request line and wait for every predicted reading to arrive
    task automatic wait_for_readings();
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(negedge clk);
    endtask

    // register writes only with the block drained and the divider settled
    task automatic write_register(logic addr, logic [CFG_DATA_W-1:0] value);
        wait_for_readings();
        repeat (QUIET_CYCLES) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        if (addr == REG_THRESHOLD)
            cur_thr = value[THR_W-1:0];
        else
            cur_len = value[WLEN_W-1:0];
        reg_writes++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Reading checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        meter_reading_t want_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("reading with no window pending: tdata %h", m_tdata);
                error_count++;
            end
            else
            begin
                want_r = pending_readings.pop_front();
                readings_checked++;
                if (m_tdata[9:0] !== want_r.pp)
                begin
                    $error("peak_to_peak: expected %0d, got %0d",
                           want_r.pp, m_tdata[9:0]);
                    error_count++;
                end
                if (m_tdata[39:10] !== want_r.freq)
                begin
                    $error("frequency_mhz: expected %0d, got %0d",
                           want_r.freq, m_tdata[39:10]);
                    error_count++;
                end
                if (m_tdata[41:40] !== want_r.periods)
                begin
                    $error("periods_seen: expected %0d, got %0d",
                           want_r.periods, m_tdata[41:40]);
                    error_count++;
                end
            end
        end
    end

    // watchdog: any request, reading or register write counts as progress
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("zero_cross_frequency_amplitude_meter_test: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset registers (threshold 512, length 1024). Full-scale square wave,
    // timestamps wrap through zero; stops early on the second rising period.
    task automatic test_reset_window();
        logic [TIME_W-1:0] base;
        base = 32'hFFFF_FFF0;
        send_sample(10'd0,    base,          1'b1);
        send_sample(10'd1023, base + 32'd4,  1'b1);  // first rising edge
        send_sample(10'd0,    base + 32'd9,  1'b0);
        send_sample(10'd1023, base + 32'd20, 1'b0);  // period 16
        send_sample(10'd0,    base + 32'd25, 1'b0);
        send_sample(10'd1023, base + 32'd36, 1'b1);  // second period, stop
    endtask

    // length below 2 clamps to 2; threshold at zero
    task automatic test_short_windows();
        write_register(REG_WINDOW, 11'd0);
        write_register(REG_THRESHOLD, 11'd0);
        send_sample(10'd5, 32'h0000_0000, 1'b0);
        send_sample(10'd9, 32'hFFFF_FFFF, 1'b0);
        write_register(REG_WINDOW, 11'd1);
        send_sample(10'd1023, 32'h5555_5555, 1'b1);
        send_sample(10'd0,    32'hAAAA_AAAA, 1'b1);
    endtask

    // equal timestamps on every crossing: zero period saturates the frequency;
    // threshold at full scale allows falling edges only; 2047 clamps to max
    task automatic test_zero_period();
        int k;
        write_register(REG_THRESHOLD, 11'd1023);
        write_register(REG_WINDOW, 11'd2047);
        for (k = 0; k < 6; k++)
            send_sample((k % 2 == 0) ? 10'd1023 : 10'd0, 32'd100, 1'b1);
    endtask

    // crossings present but frequency not requested
    task automatic test_frequency_off();
        write_register(REG_THRESHOLD, 11'd512);
        write_register(REG_WINDOW, 11'd4);
        send_sample(10'd0,    32'd10, 1'b0);
        send_sample(10'd1023, 32'd20, 1'b1);
        send_sample(10'd0,    32'd30, 1'b1);
        send_sample(10'd1023, 32'd40, 1'b1);
    endtask

    // lower threshold and shrink the window while a window is open: the next
    // sample crosses only under the new threshold and closes the window
    task automatic test_midwindow_changes();
        write_register(REG_WINDOW, 11'd10);
        send_sample(10'd0,   32'd1000, 1'b1);
        send_sample(10'd600, 32'd1100, 1'b1);  // rising edge at 512
        send_sample(10'd100, 32'd1200, 1'b0);
        write_register(REG_THRESHOLD, 11'd150);
        write_register(REG_WINDOW, 11'd3);
        send_sample(10'd160, 32'd1350, 1'b0);  // period 250, window ends
    endtask

    // phases of random settings, each a stream of square-ish waves around the
    // threshold with jitter, plus noise bursts and zero or huge time steps
    task automatic test_random_windows();
        int                phase;
        int                n;
        int                v;
        int                half;
        int                amp;
        int                step_max;
        int                chunk_left;
        int                wave_pos;
        bit                noisy;
        logic [SAMPLE_W-1:0] smp;
        logic [TIME_W-1:0] t_now;
        logic [CFG_DATA_W-1:0] wl;
        logic [CFG_DATA_W-1:0] th;
        chunk_left = 0;
        wave_pos   = 0;
        half       = 1;
        amp        = 1;
        step_max   = 1;
        noisy      = 1'b0;
        t_now      = $urandom;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       th = 11'd0;
                1:       th = 11'd1023;
                default: th = CFG_DATA_W'($urandom_range(0, 1023));
            endcase
            case ($urandom_range(0, 9))
                0:       wl = 11'd0;
                1:       wl = 11'd1;
                2:       wl = 11'd2;
                3:       wl = 11'd2047;
                4:       wl = 11'd1024;
                5, 6:    wl = CFG_DATA_W'($urandom_range(2, 300));
                default: wl = CFG_DATA_W'($urandom_range(2, 40));
            endcase
            write_register(REG_THRESHOLD, th);
            write_register(REG_WINDOW, wl);
            // first phase runs with no idling at all
            gaps_on   = (phase != 0) && ($urandom_range(0, 3) != 0);
            stalls_on = (phase != 0) && ($urandom_range(0, 3) != 0);

            for (n = 0; n < PHASE_SAMPLES; n++)
            begin
                if (chunk_left == 0)
                begin
                    half       = $urandom_range(1, 8);
                    amp        = $urandom_range(1, 600);
                    noisy      = ($urandom_range(0, 4) == 0);
                    step_max   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3000);
                    chunk_left = $urandom_range(4, 40);
                end
                chunk_left--;
                if (noisy)
                    smp = SAMPLE_W'($urandom_range(0, 1023));
                else
                begin
                    v = int'(cur_thr) + (((wave_pos / half) % 2 == 0) ? amp : -amp)
                        + int'($urandom_range(0, 20)) - 10;
                    if (v < 0)
                        v = 0;
                    if (v > 1023)
                        v = 1023;
                    smp = v[SAMPLE_W-1:0];
                end
                wave_pos++;
                if ($urandom_range(0, 50) == 0)
                    t_now = t_now + $urandom;
                else if (step_max != 0)
                    t_now = t_now + $urandom_range(1, step_max);
                send_sample(smp, t_now, $urandom_range(0, 3) != 0);
                // hold off mid-phase until the block has caught up
                if (n == PHASE_SAMPLES / 2 && phase % 3 == 1)
                    wait_for_readings();
            end
        end
    endtask

    // one window at the largest length, frequency off, full-range samples
    task automatic test_longest_window();
        int k;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        // close whatever window is open so the next sample starts one
        write_register(REG_WINDOW, 11'd2);
        while (win_pos != 0)
            send_sample(SAMPLE_W'($urandom_range(0, 1023)), $urandom, 1'b0);
        write_register(REG_WINDOW, 11'd2047);
        send_sample(SAMPLE_W'($urandom_range(0, 1023)), $urandom, 1'b0);
        for (k = 1; k < MAX_WINDOW_DEF; k++)
            send_sample(SAMPLE_W'($urandom_range(0, 1023)), $urandom,
                        1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        test_reset_window();
        test_short_windows();
        test_zero_period();
        test_frequency_off();
        test_midwindow_changes();
        test_random_windows();
        test_longest_window();

        wait_for_readings();
        repeat (QUIET_CYCLES) @(negedge clk);
        if (pending_readings.size() != 0)
        begin
            $error("%0d readings never arrived", pending_readings.size());
            error_count++;
        end

        $display("run: %0d samples, %0d window readings checked, %0d register writes",
                 samples_sent, readings_checked, reg_writes);
        $display("run: lengths 0..2047 incl. clamps, thresholds at both rails, "
                 , "early stops, zero periods, mid-window changes");
        if (error_count == 0)
            $display("zero_cross_frequency_amplitude_meter_test: clean");
        else
            $display("zero_cross_frequency_amplitude_meter_test: errors");
        $finish;
    end

endmodule
